/* hdl/sorted_array_priority_queue_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the sorted array priority queue
// Concurrent assertion wrappers that are left out of synthesis builds.
// ----------------------------------------------------------------------------
`ifndef SORTED_ARRAY_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define SORTED_ARRAY_PRIORITY_QUEUE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is high.
`define SPAQ_ASSERT_IMPL(name, clk, rst, cond, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SPAQ_ASSERT_NEXT(name, clk, rst, cond, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`else

`define SPAQ_ASSERT_IMPL(name, clk, rst, cond, prop, msg)
`define SPAQ_ASSERT_NEXT(name, clk, rst, cond, prop, msg)

`endif

`endif

/* hdl/spaq_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted array priority queue package
// Request codes, register indexes, cell operation codes and the cell control.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spaq_pkg;

   // Request codes on req_type.
   localparam logic [1:0] REQ_PUSH = 2'd0;
   localparam logic [1:0] REQ_POP  = 2'd1;
   localparam logic [1:0] REQ_TOP  = 2'd2;

   // Configuration register indexes.
   localparam logic CSR_CAPACITY_LIMIT   = 1'b0;
   localparam logic CSR_ORDER_DESCENDING = 1'b1;

   localparam int unsigned CSR_DATA_WIDTH = 7;
   localparam int unsigned COUNT_OUT_WIDTH = 7;
   localparam int unsigned FRONT_WIDTH = 32;
   localparam logic [6:0] CAPACITY_RESET = 7'd64;

   // What a cell does with its key at the next edge.
   localparam logic [1:0] CELL_HOLD       = 2'd0;
   localparam logic [1:0] CELL_LOAD_NEW   = 2'd1;
   localparam logic [1:0] CELL_SHIFT_BACK = 2'd2;
   localparam logic [1:0] CELL_SHIFT_FWD  = 2'd3;

   typedef struct packed {
      logic [1:0] op;
   } cell_ctl_type;

endpackage

/* hdl/spaq_cell.sv */
// ----------------------------------------------------------------------------
// Sorted array priority queue cell
// Holds one key, compares it with the incoming key and moves it on command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spaq_cell #(
   parameter int unsigned KEY_WIDTH = 32
) (
   input  logic                  clock,
   input  spaq_pkg::cell_ctl_type ctl,
   input  logic                  order_desc,
   input  logic                  in_use,
   input  logic [KEY_WIDTH-1:0]  new_key,
   input  logic [KEY_WIDTH-1:0]  left_key,
   input  logic [KEY_WIDTH-1:0]  right_key,
   output logic [KEY_WIDTH-1:0]  key,
   output logic                  behind
);

   logic [KEY_WIDTH-1:0] key_ff;
   logic [KEY_WIDTH-1:0] key_in;

   // The held key must stand behind the incoming key under the current order.
   assign behind = in_use && (order_desc ? (key_ff < new_key) : (key_ff > new_key));
   assign key    = key_ff;

   always_comb begin
      case (ctl.op)
         spaq_pkg::CELL_LOAD_NEW:   key_in = new_key;
         spaq_pkg::CELL_SHIFT_BACK: key_in = left_key;
         spaq_pkg::CELL_SHIFT_FWD:  key_in = right_key;
         default:                   key_in = key_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

endmodule

/* hdl/sorted_array_priority_queue_unit.sv */
// ----------------------------------------------------------------------------
// Sorted array priority queue unit
// A priority queue held in a row of key cells, front key in cell zero.
// ----------------------------------------------------------------------------
// Each transaction (push, pop or top) is taken when start is high and its
// response shows on the rsp_ ports in the next cycle, marked by rsp_valid for
// exactly one cycle; the receiver cannot stall, so busy stays low and a new
// transaction may be started on every cycle. The rate is set by the row of
// cells: every cell compares its key with the incoming key in parallel, the
// insertion point is found from those flags, and every cell loads, shifts or
// holds at the same edge. Equal keys keep their arrival order. Pushes fail
// once the count reaches the smaller of capacity_limit and DEPTH, pops and
// tops fail on an empty queue, and a failed or unused request answers with a
// zero front value and the current count. Keys are not reordered when the
// order bit is changed. Cells above the count hold undefined keys.
`timescale 1ns / 1ps

`include "sorted_array_priority_queue_unit_assert.svh"

module sorted_array_priority_queue_unit #(
   parameter int unsigned DEPTH     = 64,
   parameter int unsigned KEY_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_type,
   input  logic [31:0] req_item_value,
   // Response channel.
   output logic        rsp_valid,
   output logic        rsp_success,
   output logic [31:0] rsp_front_value,
   output logic [6:0]  rsp_entry_count,
   // Configuration port.
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [6:0]  csr_wdata
);

   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam int unsigned CMP_W = (CNT_W > 7) ? CNT_W : 7;

   // ---------------------------------------------------------------------
   // Configuration registers.
   // ---------------------------------------------------------------------
   logic [6:0] capacity_ff;
   logic       order_desc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff   <= spaq_pkg::CAPACITY_RESET;
         order_desc_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_addr)
            spaq_pkg::CSR_CAPACITY_LIMIT:   capacity_ff   <= csr_wdata;
            spaq_pkg::CSR_ORDER_DESCENDING: order_desc_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Request decode. Work finishes in the cycle of acceptance, so the block
   // is never busy.
   // ---------------------------------------------------------------------
   logic                 accept;
   logic [CNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]     count_in;
   logic                 push_ok;
   logic                 pop_ok;
   logic                 top_ok;
   logic [63:0]          item_ext;
   logic [KEY_WIDTH-1:0] new_key;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // The push limit is the smaller of capacity_limit and DEPTH.
   assign push_ok = accept && (req_type == spaq_pkg::REQ_PUSH)
                    && (CMP_W'(count_ff) < CMP_W'(capacity_ff))
                    && (count_ff < CNT_W'(DEPTH));
   assign pop_ok  = accept && (req_type == spaq_pkg::REQ_POP) && (count_ff != '0);
   assign top_ok  = accept && (req_type == spaq_pkg::REQ_TOP) && (count_ff != '0);

   // Keys are masked to KEY_WIDTH bits on entry.
   assign item_ext = 64'(req_item_value);
   assign new_key  = item_ext[KEY_WIDTH-1:0];

   always_comb begin
      count_in = count_ff;
      if (push_ok) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop_ok) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // ---------------------------------------------------------------------
   // Cell row. Each cell raises its behind flag when its held key must
   // stand behind the new key; the push goes into the first flagged cell,
   // or into the cell at the count when no cell is flagged. Every cell after
   // the first flag takes its left neighbour's key. Since the keys may not
   // be sorted after an order change, the first flag is found from a prefix
   // of all flags rather than from neighbouring flags alone.
   // ---------------------------------------------------------------------
   logic [KEY_WIDTH-1:0] cell_key [DEPTH];
   logic [DEPTH-1:0]     behind_vec;
   logic [DEPTH-1:0]     earlier_vec;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      localparam logic [DEPTH-1:0] LOWER_MASK = {DEPTH{1'b1}} >> (DEPTH - i);

      spaq_pkg::cell_ctl_type ctl;
      logic                   in_use;
      logic                   at_tail;
      logic [KEY_WIDTH-1:0]   left_key;
      logic [KEY_WIDTH-1:0]   right_key;

      assign in_use         = CNT_W'(i) < count_ff;
      assign at_tail        = CNT_W'(i) == count_ff;
      assign earlier_vec[i] = |(behind_vec & LOWER_MASK);

      if (i == 0) begin : g_head
         assign left_key = new_key;
      end else begin : g_body
         assign left_key = cell_key[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_key = cell_key[i];
      end else begin : g_inner
         assign right_key = cell_key[i+1];
      end

      always_comb begin
         ctl.op = spaq_pkg::CELL_HOLD;
         if (pop_ok) begin
            ctl.op = spaq_pkg::CELL_SHIFT_FWD;
         end else if (push_ok) begin
            if (earlier_vec[i]) begin
               ctl.op = spaq_pkg::CELL_SHIFT_BACK;
            end else if (behind_vec[i] || at_tail) begin
               ctl.op = spaq_pkg::CELL_LOAD_NEW;
            end
         end
      end

      spaq_cell #(
         .KEY_WIDTH (KEY_WIDTH)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .order_desc (order_desc_ff),
         .in_use     (in_use),
         .new_key    (new_key),
         .left_key   (left_key),
         .right_key  (right_key),
         .key        (cell_key[i]),
         .behind     (behind_vec[i])
      );
   end

   // ---------------------------------------------------------------------
   // Count and response registers.
   // ---------------------------------------------------------------------
   logic        rsp_valid_ff;
   logic        rsp_success_ff;
   logic [31:0] rsp_front_ff;
   logic [6:0]  rsp_count_ff;
   logic [63:0] front_ext;

   assign front_ext = 64'(cell_key[0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_success_ff <= push_ok || pop_ok || top_ok;
         rsp_front_ff   <= (pop_ok || top_ok) ? front_ext[31:0] : 32'd0;
         rsp_count_ff   <= 7'(count_in);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_success     = rsp_success_ff;
   assign rsp_front_value = rsp_front_ff;
   assign rsp_entry_count = rsp_count_ff;

   // ---------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------
   `SPAQ_ASSERT_IMPL(a_count_in_range, clock, reset, 1'b1,
      count_ff <= CNT_W'(DEPTH), "count above depth")
   `SPAQ_ASSERT_NEXT(a_one_response, clock, reset, accept,
      rsp_valid_ff, "missing response strobe")
   `SPAQ_ASSERT_NEXT(a_push_grows, clock, reset, push_ok,
      count_ff == $past(count_ff) + CNT_W'(1), "push did not grow the count")
   `SPAQ_ASSERT_IMPL(a_fail_zero_front, clock, reset, rsp_valid_ff && !rsp_success_ff,
      rsp_front_ff == 32'd0, "failed response with non-zero front")

endmodule
